>>> hdl/ppm_pkg.sv
`timescale 1ns / 1ps

package ppm_pkg;

    localparam int DIM_W   = 14;
    localparam int ACC_W   = 16;
    localparam int COUNT_W = 28;
    localparam int AREA_W  = 2 * DIM_W;

    localparam logic [DIM_W-1:0] DIM_RESET = 14'd8192;
    localparam logic [ACC_W-1:0] MAXVAL    = 16'd255;
    localparam logic [ACC_W-1:0] ACC_SAT   = 16'hFFFF;

    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_SIX  = 8'h36;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    localparam logic [2:0] ERR_MAGIC     = 3'd0;
    localparam logic [2:0] ERR_WIDTH     = 3'd1;
    localparam logic [2:0] ERR_HEIGHT    = 3'd2;
    localparam logic [2:0] ERR_MAXVAL    = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    typedef enum logic [3:0] {
        PH_MAGIC_P   = 4'd0,
        PH_MAGIC_6   = 4'd1,
        PH_SEP       = 4'd2,
        PH_WS_W      = 4'd3,
        PH_CMT_W     = 4'd4,
        PH_NUM_W     = 4'd5,
        PH_WS_H      = 4'd6,
        PH_CMT_H     = 4'd7,
        PH_NUM_H     = 4'd8,
        PH_WS_M      = 4'd9,
        PH_CMT_M     = 4'd10,
        PH_NUM_M     = 4'd11,
        PH_TAIL_CMT  = 4'd12,
        PH_TAIL_SKIP = 4'd13,
        PH_PIXELS    = 4'd14,
        PH_DONE      = 4'd15
    } phase_t;

    typedef struct packed {
        kind_t            kind;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [7:0]       pixel_byte;
        logic             last_pixel;
        logic [2:0]       error_code;
    } res_t;

endpackage

>>> hdl/ppm_p6_header_parser_core.sv
// Binary PPM (P6) header parser. One file byte is taken per clock cycle
// while in_stall is low; every byte is finished in one registered pass:
// the phase register and the number accumulator are updated on the
// accepting edge and the result (header size, pixel byte or error) lands
// on the same edge in the output register, or in the skid stage behind
// it while the output stalls; a byte can thus be taken while a result
// waits, and in_stall rises only once both are full. The pixel count
// width*height*3 comes from a registered multiplier fed by the held size.
// The user must write max_dimension (cfg_write/cfg_data) only while the
// block is idle, which the block does not enforce; it resets to 8192.
`timescale 1ns / 1ps

module ppm_p6_header_parser_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [ppm_pkg::DIM_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       end_of_file,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 kind,
    output logic [ppm_pkg::DIM_W-1:0]  image_width,
    output logic [ppm_pkg::DIM_W-1:0]  image_height,
    output logic [7:0]                 pixel_byte,
    output logic                       last_pixel,
    output logic [2:0]                 error_code
);

    import ppm_pkg::*;

    phase_t              phase_reg, phase_next, phase_step;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [DIM_W-1:0]    width_reg, width_next;
    logic [DIM_W-1:0]    height_reg, height_next;
    logic [COUNT_W-1:0]  remain_reg, remain_next;
    logic                cr_reg, cr_next;
    logic [DIM_W-1:0]    max_dim_reg;
    logic [AREA_W-1:0]   area_reg;

    res_t                out_reg, skid_reg, res;
    logic                out_valid_reg, skid_valid_reg;

    logic                in_accept;
    logic                is_space, is_hash, is_digit, is_cr, is_lf;
    logic [ACC_W+3:0]    acc_x10;
    logic [ACC_W-1:0]    acc_sat;
    logic                dim_ok;
    logic [AREA_W+1:0]   total_wide;
    logic [COUNT_W-1:0]  pixel_total;
    logic [COUNT_W-1:0]  remain_dec;
    logic                err_valid;
    logic [2:0]          err_code;
    logic                start_pix;
    logic                pix_out;
    logic                produce;
    logic                out_free;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = skid_valid_reg;

    assign is_cr    = (data_byte == CHAR_CR);
    assign is_lf    = (data_byte == CHAR_LF);
    assign is_hash  = (data_byte == CHAR_HASH);
    assign is_space = (data_byte == CHAR_TAB) || is_lf || is_cr || (data_byte == CHAR_SP);
    assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);

    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                   + {16'b0, data_byte[3:0]};
    assign acc_sat = (|acc_x10[ACC_W+3:ACC_W]) ? ACC_SAT : acc_x10[ACC_W-1:0];
    assign dim_ok  = (acc_reg != '0) && (acc_reg <= {2'b0, max_dim_reg});

    assign total_wide  = {2'b0, area_reg} + {1'b0, area_reg, 1'b0};
    assign pixel_total = total_wide[COUNT_W-1:0];
    assign remain_dec  = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;

    // byte decode: errors, header report, pixel pass
    always_comb
    begin
        err_valid = 1'b0;
        err_code  = ERR_MAGIC;
        start_pix = 1'b0;
        pix_out   = 1'b0;
        unique case (phase_reg)
            PH_MAGIC_P:
            begin
                err_valid = (data_byte != CHAR_P);
            end
            PH_MAGIC_6:
            begin
                err_valid = (data_byte != CHAR_SIX);
            end
            PH_SEP:
            begin
                err_valid = !(is_space || is_hash);
            end
            PH_WS_W:
            begin
                err_valid = !(is_space || is_hash || is_digit);
                err_code  = ERR_WIDTH;
            end
            PH_WS_H:
            begin
                err_valid = !(is_space || is_hash || is_digit);
                err_code  = ERR_HEIGHT;
            end
            PH_WS_M:
            begin
                err_valid = !(is_space || is_hash || is_digit);
                err_code  = ERR_MAXVAL;
            end
            PH_NUM_W:
            begin
                if (!is_digit)
                begin
                    if (!dim_ok)
                    begin
                        err_valid = 1'b1;
                        err_code  = ERR_WIDTH;
                    end
                    else if (!(is_space || is_hash))
                    begin
                        err_valid = 1'b1;
                        err_code  = ERR_HEIGHT;
                    end
                end
            end
            PH_NUM_H:
            begin
                if (!is_digit)
                begin
                    if (!dim_ok)
                    begin
                        err_valid = 1'b1;
                        err_code  = ERR_HEIGHT;
                    end
                    else if (!(is_space || is_hash))
                    begin
                        err_valid = 1'b1;
                        err_code  = ERR_MAXVAL;
                    end
                end
            end
            PH_NUM_M:
            begin
                if (!is_digit)
                begin
                    if (acc_reg != MAXVAL)
                    begin
                        err_valid = 1'b1;
                        err_code  = ERR_MAXVAL;
                    end
                    else if (!is_hash)
                    begin
                        start_pix = 1'b1;
                    end
                end
            end
            PH_TAIL_CMT:
            begin
                start_pix = cr_reg && !is_lf;
            end
            PH_TAIL_SKIP:
            begin
                start_pix = 1'b1;
            end
            PH_PIXELS:
            begin
                pix_out = 1'b1;
            end
            PH_CMT_W, PH_CMT_H, PH_CMT_M, PH_DONE:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        phase_step  = phase_reg;
        acc_next    = acc_reg;
        width_next  = width_reg;
        height_next = height_reg;
        remain_next = remain_reg;
        cr_next     = cr_reg;
        unique case (phase_reg)
            PH_MAGIC_P:
            begin
                phase_step = PH_MAGIC_6;
            end
            PH_MAGIC_6:
            begin
                phase_step = PH_SEP;
            end
            PH_SEP:
            begin
                phase_step = is_hash ? PH_CMT_W : PH_WS_W;
            end
            PH_WS_W, PH_WS_H, PH_WS_M:
            begin
                if (is_hash)
                begin
                    phase_step = phase_t'(phase_reg + 4'd1);
                end
                else if (is_digit)
                begin
                    acc_next   = {12'b0, data_byte[3:0]};
                    phase_step = phase_t'(phase_reg + 4'd2);
                end
            end
            PH_CMT_W, PH_CMT_H, PH_CMT_M:
            begin
                if (is_cr || is_lf)
                begin
                    phase_step = phase_t'(phase_reg - 4'd1);
                end
            end
            PH_NUM_W:
            begin
                if (is_digit)
                begin
                    acc_next = acc_sat;
                end
                else
                begin
                    width_next = acc_reg[DIM_W-1:0];
                    phase_step = is_hash ? PH_CMT_H : PH_WS_H;
                end
            end
            PH_NUM_H:
            begin
                if (is_digit)
                begin
                    acc_next = acc_sat;
                end
                else
                begin
                    height_next = acc_reg[DIM_W-1:0];
                    phase_step  = is_hash ? PH_CMT_M : PH_WS_M;
                end
            end
            PH_NUM_M:
            begin
                if (is_digit)
                begin
                    acc_next = acc_sat;
                end
                else if (is_hash)
                begin
                    phase_step = PH_TAIL_CMT;
                    cr_next    = 1'b0;
                end
            end
            PH_TAIL_CMT:
            begin
                if (cr_reg)
                begin
                    cr_next = 1'b0;
                    if (is_lf)
                    begin
                        phase_step = PH_TAIL_SKIP;
                    end
                end
                else if (is_cr)
                begin
                    cr_next = 1'b1;
                end
                else if (is_lf)
                begin
                    phase_step = PH_TAIL_SKIP;
                end
            end
            PH_PIXELS:
            begin
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    phase_step = PH_DONE;
                end
            end
            PH_TAIL_SKIP, PH_DONE:
            begin
            end
        endcase
        if (start_pix)
        begin
            remain_next = pixel_total;
            phase_step  = PH_PIXELS;
        end
        if (err_valid)
        begin
            phase_step = PH_DONE;
        end
        phase_next = phase_step;
        if (end_of_file)
        begin
            phase_next  = PH_MAGIC_P;
            acc_next    = '0;
            width_next  = '0;
            height_next = '0;
            remain_next = '0;
            cr_next     = 1'b0;
        end
    end

    // result of the byte
    always_comb
    begin
        res     = '0;
        produce = 1'b1;
        if (err_valid)
        begin
            res.kind       = KIND_ERROR;
            res.error_code = err_code;
        end
        else if (end_of_file && (phase_step != PH_DONE))
        begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRUNCATED;
        end
        else if (start_pix)
        begin
            res.kind         = KIND_HEADER;
            res.image_width  = width_reg;
            res.image_height = height_reg;
        end
        else if (pix_out)
        begin
            res.kind       = KIND_PIXEL;
            res.pixel_byte = data_byte;
            res.last_pixel = (remain_dec == '0);
        end
        else
        begin
            produce = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC_P;
            acc_reg     <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            remain_reg  <= '0;
            cr_reg      <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            remain_reg  <= remain_next;
            cr_reg      <= cr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dim_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            max_dim_reg <= cfg_data;
        end
    end

    // size product; the held size is settled several bytes before it is used
    always_ff @(posedge clk)
    begin
        area_reg <= width_reg * height_reg;
    end

    // output register and skid stage
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept && produce;
            end
        end
        else if (in_accept && produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (in_accept && produce)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign image_width  = out_reg.image_width;
    assign image_height = out_reg.image_height;
    assign pixel_byte   = out_reg.pixel_byte;
    assign last_pixel   = out_reg.last_pixel;
    assign error_code   = out_reg.error_code;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    a_error_ends_file: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && err_valid && !end_of_file) |=> (phase_reg == PH_DONE))
        else $error("error did not end the file");

    a_pixels_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXELS) |-> (remain_reg != '0))
        else $error("pixel phase with no bytes remaining");

    a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && end_of_file) |=> (phase_reg == PH_MAGIC_P && acc_reg == '0))
        else $error("end of file did not restart the parser");
`endif

endmodule
